// File: rtl/core/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;

    localparam int MAX_LOD_DEF         = 64;
    localparam int ANGLE_BITS_DEF      = 16;
    localparam int COORD_FRAC_BITS_DEF = 14;

    localparam int LOD_W   = 7;
    localparam int STEP_W  = 16;
    localparam int STACK_W = 6;
    localparam int SECT_W  = 7;
    localparam int POS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'b1;

    localparam logic [LOD_W-1:0]  LOD_RESET  = 7'd10;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;

    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN_START = 34'sd652032874;

    // one cordic angle entry per step, in 2^32 turn units
    function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] k);
        logic signed [CW-1:0] r;
        unique case (k)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // shift toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                     input logic [4:0] s);
        logic signed [CW-1:0] m;
        m = v[CW-1] ? -v : v;
        m = m >>> s;
        return v[CW-1] ? -m : m;
    endfunction

endpackage

// File: rtl/core/uvs_stream_if.sv
`timescale 1ns / 1ps
interface uvs_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/uvs_cell_if.sv
`timescale 1ns / 1ps
interface uvs_cell_if;
    logic                          valid;
    logic                          ready;
    logic [uvs_pkg::STACK_W-1:0]   stack_index;
    logic [uvs_pkg::SECT_W-1:0]    sector_index;
    modport source (output valid, output stack_index, output sector_index, input ready);
    modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

// File: rtl/core/uvs_vertex_if.sv
`timescale 1ns / 1ps
interface uvs_vertex_if;
    logic                              valid;
    logic                              ready;
    logic signed [uvs_pkg::POS_W-1:0]  pos_x;
    logic signed [uvs_pkg::POS_W-1:0]  pos_y;
    logic signed [uvs_pkg::POS_W-1:0]  pos_z;
    logic                              is_last;
    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output is_last, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input is_last, output ready);
endinterface

// File: rtl/core/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// uv sphere vertex generator: each cell beat (stack i, sector j) yields up to six
// vertex beats of two triangles, in Q1.14, last one flagged with is_last. The front
// part turns a cell into one angle pair per vertex at one per cycle while the queue
// accepts, and the next cell beat is taken in the cycle its last pair leaves;
// a two-entry queue sits between front and back. The back part is a 33-register
// pipeline of two 30-step cordics, the products and rounding, giving one vertex per
// cycle unless the output stalls. Cells outside the grid are dropped without output.
module uv_sphere_vertex_generator #(
    parameter int MAX_LOD         = uvs_pkg::MAX_LOD_DEF,
    parameter int ANGLE_BITS      = uvs_pkg::ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    uvs_cell_if.sink                      tile,
    uvs_vertex_if.source                  vertex,
    input  logic                          cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]     cfg_data
);
    localparam int JW = 2 * ANGLE_BITS + 1;

    logic [uvs_pkg::LOD_W-1:0]  lod_reg;
    logic [uvs_pkg::STEP_W-1:0] step_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lod_reg  <= uvs_pkg::LOD_RESET;
            step_reg <= uvs_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_LOD:  lod_reg  <= cfg_data[uvs_pkg::LOD_W-1:0];
                uvs_pkg::REG_STEP: step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    uvs_stream_if #(.W(JW)) f2q ();
    uvs_stream_if #(.W(JW)) q2b ();

    uvs_front #(.MAX_LOD(MAX_LOD), .ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .tile(tile), .lod(lod_reg), .step(step_reg), .job(f2q)
    );
    uvs_queue #(.W(JW)) u_queue (.clk(clk), .rst_n(rst_n), .din(f2q), .dout(q2b));
    uvs_back #(.ANGLE_BITS(ANGLE_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job(q2b), .vtx(vertex)
    );

    // pos_y stays within the unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> (vertex.pos_y <= 16'sd16384 && vertex.pos_y >= -16'sd16384))
        else $error("pos_y out of range");
    // a stalled result stays valid and holds pos_x
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid && !vertex.ready |=> vertex.valid && $stable(vertex.pos_x))
        else $error("vertex dropped while stalled");
endmodule

// File: rtl/core/uvs_front.sv
`timescale 1ns / 1ps
// classifies a cell and queues one angle pair per vertex
module uvs_front #(
    parameter int MAX_LOD    = uvs_pkg::MAX_LOD_DEF,
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    uvs_cell_if.sink                    tile,
    input  logic [uvs_pkg::LOD_W-1:0]   lod,
    input  logic [uvs_pkg::STEP_W-1:0]  step,
    uvs_stream_if.source                job
);
    localparam int LW = $clog2(MAX_LOD + 1);

    logic [LW-1:0]          lod_c;
    logic [ANGLE_BITS-1:0]  a_reg, a1_reg, b_reg, b1_reg;
    logic [5:0]             seq_reg;     // pending vertex slots, one bit each
    logic [ANGLE_BITS-1:0]  a_n, b_n, stp;
    logic                   in_grid;
    logic [5:0]             seq_n;
    logic [2:0]             nxt;
    logic                   sel_a1, sel_b1;
    logic [5:0]             rem;

    assign stp = ANGLE_BITS'(step);
    always_comb
    begin
        if (32'(lod) > MAX_LOD) lod_c = LW'(MAX_LOD);
        else                    lod_c = LW'(lod);
    end

    assign in_grid = (32'(tile.stack_index) < 32'(lod_c)) &&
                     (32'(tile.sector_index) < 2 * 32'(lod_c));
    assign a_n = ANGLE_BITS'(tile.stack_index * stp) - ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    assign b_n = ANGLE_BITS'(tile.sector_index * stp);
    always_comb
    begin
        seq_n[2:0] = (tile.stack_index != '0) ? 3'b111 : 3'b000;
        seq_n[5:3] = (32'(tile.stack_index) != 32'(lod_c) - 1) ? 3'b111 : 3'b000;
    end

    // lowest pending slot
    always_comb
    begin
        nxt = 3'd0;
        for (int k = 5; k >= 0; k--)
            if (seq_reg[k]) nxt = 3'(k);
    end

    always_comb
    begin
        unique case (nxt)
            3'd1, 3'd4: begin sel_a1 = 1'b1; sel_b1 = 1'b0; end
            3'd2, 3'd3: begin sel_a1 = 1'b0; sel_b1 = 1'b1; end
            3'd5:       begin sel_a1 = 1'b1; sel_b1 = 1'b1; end
            default:    begin sel_a1 = 1'b0; sel_b1 = 1'b0; end
        endcase
        rem = seq_reg & ~(6'd1 << nxt);
    end

    assign tile.ready = (seq_reg == '0) || (job.ready && rem == '0);
    assign job.valid  = (seq_reg != '0);
    assign job.data   = {sel_a1 ? a1_reg : a_reg, sel_b1 ? b1_reg : b_reg, (rem == '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
        end
        else if (tile.valid && tile.ready)
        begin
            seq_reg <= in_grid ? seq_n : 6'd0;
        end
        else if (job.valid && job.ready)
        begin
            seq_reg <= rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tile.valid && tile.ready)
        begin
            a_reg  <= a_n;
            a1_reg <= a_n + stp;
            b_reg  <= b_n;
            b1_reg <= b_n + stp;
        end
    end
endmodule

// File: rtl/core/uvs_queue.sv
`timescale 1ns / 1ps
// two-entry queue between front and back
module uvs_queue #(
    parameter int W = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    uvs_stream_if.sink    din,
    uvs_stream_if.source  dout
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign din.ready  = (cnt_reg != 2'd2);
    assign dout.valid = (cnt_reg != 2'd0);
    assign dout.data  = mem_reg[rp_reg];
    assign wr = din.valid && din.ready;
    assign rd = dout.valid && dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= din.data;
    end
endmodule

// File: rtl/core/uvs_back.sv
`timescale 1ns / 1ps
// pipelined cordic pair and products, one vertex per cycle unless the output stalls
module uvs_back #(
    parameter int ANGLE_BITS      = uvs_pkg::ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    uvs_stream_if.sink     job,
    uvs_vertex_if.source   vtx
);
    localparam int N  = uvs_pkg::CORDIC_STEPS;
    localparam int CW = uvs_pkg::CW;
    localparam int D  = N + 3;   // cordic stages, products, rounding, output
    localparam int PW = 2 * CW;

    typedef struct packed {
        logic signed [CW-1:0] x, y, z;
    } rot_t;

    logic               v_reg [D];
    logic               l_reg [D];
    rot_t               ra_reg [N+1];
    rot_t               rb_reg [N+1];
    logic               fa_reg [N+1];
    logic               fb_reg [N+1];
    logic signed [PW-1:0] px_reg, pz_reg;
    logic signed [CW-1:0] py_reg;
    logic signed [uvs_pkg::POS_W-1:0] ox_reg, oy_reg, oz_reg;
    logic               adv;
    logic [ANGLE_BITS-1:0] ang_a, ang_b;
    logic               last_in;

    // advance when output slot is free or taken
    assign adv = !v_reg[D-1] || vtx.ready;
    assign job.ready = adv;
    assign {ang_a, ang_b, last_in} = job.data;

    function automatic rot_t prep(input logic [ANGLE_BITS-1:0] ang, output logic flip);
        logic [31:0] t;
        rot_t r;
        t = 32'(ang) << (32 - ANGLE_BITS);
        flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
        if (flip) t = t + 32'h8000_0000;
        r.x = uvs_pkg::CORDIC_GAIN_START;
        r.y = '0;
        r.z = CW'(signed'(t));
        return r;
    endfunction

    function automatic rot_t rot(input rot_t r, input logic [4:0] k);
        rot_t o;
        logic signed [CW-1:0] dx, dy;
        dx = uvs_pkg::shr_trunc(r.y, k);
        dy = uvs_pkg::shr_trunc(r.x, k);
        if (!r.z[CW-1])
        begin
            o.x = r.x - dx; o.y = r.y + dy; o.z = r.z - uvs_pkg::atan_turn(k);
        end
        else
        begin
            o.x = r.x + dx; o.y = r.y - dy; o.z = r.z + uvs_pkg::atan_turn(k);
        end
        return o;
    endfunction

    function automatic logic signed [uvs_pkg::POS_W-1:0] rsat(
        input logic signed [PW-1:0] v, input int s);
        logic signed [PW-1:0] r, lim;
        lim = PW'(1) <<< COORD_FRAC_BITS;
        r = (v + (PW'(1) <<< (s - 1))) >>> s;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return uvs_pkg::POS_W'(r);
    endfunction

    logic fa_n, fb_n;
    rot_t pa_n, pb_n;
    always_comb
    begin
        pa_n = prep(ang_a, fa_n);
        pb_n = prep(ang_b, fb_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < D; k++) v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= job.valid;
            for (int k = 1; k < D; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg[0] <= pa_n; rb_reg[0] <= pb_n;
            fa_reg[0] <= fa_n; fb_reg[0] <= fb_n;
            l_reg[0]  <= last_in;
            for (int k = 0; k < N; k++)
            begin
                ra_reg[k+1] <= rot(ra_reg[k], 5'(k));
                rb_reg[k+1] <= rot(rb_reg[k], 5'(k));
                fa_reg[k+1] <= fa_reg[k];
                fb_reg[k+1] <= fb_reg[k];
            end
            for (int k = 1; k < D; k++) l_reg[k] <= l_reg[k-1];
            // stage N+1: products with quadrant fix
            px_reg <= PW'(fa_reg[N] ? -ra_reg[N].x : ra_reg[N].x) *
                      PW'(fb_reg[N] ? -rb_reg[N].x : rb_reg[N].x);
            pz_reg <= PW'(fa_reg[N] ? -ra_reg[N].x : ra_reg[N].x) *
                      PW'(fb_reg[N] ? -rb_reg[N].y : rb_reg[N].y);
            py_reg <= fa_reg[N] ? -ra_reg[N].y : ra_reg[N].y;
            // stage N+2: round and clamp
            ox_reg <= rsat(px_reg, 60 - COORD_FRAC_BITS);
            oz_reg <= rsat(pz_reg, 60 - COORD_FRAC_BITS);
            oy_reg <= rsat(PW'(py_reg), 30 - COORD_FRAC_BITS);
        end
    end

    assign vtx.valid   = v_reg[D-1];
    assign vtx.pos_x   = ox_reg;
    assign vtx.pos_y   = oy_reg;
    assign vtx.pos_z   = oz_reg;
    assign vtx.is_last = l_reg[D-1];
endmodule
